/* hw/rtl/wcsc_pkg.sv */
// Package for the weighted centroid and sigma clip block.
// Holds the controller state type, the command and status structs and shared constants.
// No dependencies.
`timescale 1ns / 1ps

package wcsc_pkg;

   localparam logic [62:0] SAT63 = {63{1'b1}};

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_LOAD_DRAIN,
      ST_DIV_X,
      ST_DIV_Y,
      ST_PASS,
      ST_PASS_DRAIN,
      ST_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_en;
      logic div_start;
      logic div_sel;
      logic pass_start;
      logic pass_issue;
      logic finish;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic load_busy;
      logic div_done;
      logic fit_gt1;
      logic issue_last;
      logic pipe_busy;
      logic out_free;
   } sts_type;

endpackage

/* hw/rtl/wcsc_div.sv */
// Restoring divider, one quotient bit per cycle, signed dividend over unsigned divisor.
// A zero divisor gives a zero quotient. Depends on nothing but the clock and reset.
`timescale 1ns / 1ps

module wcsc_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [63:0] dividend,
   input  logic        [63:0] divisor,
   output logic               done,
   output logic signed [31:0] quotient
);

   logic        busy_ff;
   logic        done_ff;
   logic [5:0]  cnt_ff;
   logic [63:0] rem_ff;
   logic [63:0] quo_ff;
   logic [63:0] den_ff;
   logic        neg_ff;
   logic        zero_ff;
   logic [63:0] rem_sh;
   logic        ge;
   logic [63:0] rem_in;
   logic [63:0] quo_in;

   always_comb begin
      rem_sh = {rem_ff[62:0], quo_ff[63]};
      ge     = (rem_sh >= den_ff);
      rem_in = ge ? (rem_sh - den_ff) : rem_sh;
      quo_in = {quo_ff[62:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= '0;
         quo_ff  <= dividend[63] ? 64'(-dividend) : 64'(dividend);
         den_ff  <= divisor;
         neg_ff  <= dividend[63];
         zero_ff <= (divisor == 64'd0);
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign done     = done_ff;
   assign quotient = zero_ff ? 32'sd0 :
                     (neg_ff ? $signed(-quo_ff[31:0]) : $signed(quo_ff[31:0]));

endmodule

/* hw/rtl/wcsc_datapath.sv */
// Datapath: detection store, load accumulators, shared divider, deviation pipeline
// and the result register. Depends on wcsc_pkg and wcsc_div.
`timescale 1ns / 1ps

module wcsc_datapath #(
   parameter int MAX_DETECTIONS = 64,
   parameter int POS_BITS       = 32,
   parameter int WEIGHT_BITS    = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  wcsc_pkg::cmd_type             cmd,
   output wcsc_pkg::sts_type             sts,
   input  logic signed [POS_BITS-1:0]    pos_x,
   input  logic signed [POS_BITS-1:0]    pos_y,
   input  logic [WEIGHT_BITS-1:0]        weight_x,
   input  logic [WEIGHT_BITS-1:0]        weight_y,
   input  logic [WEIGHT_BITS-1:0]        clip_wx,
   input  logic [WEIGHT_BITS-1:0]        clip_wy,
   input  logic                          already_clipped,
   input  logic [62:0]                   clip_thr,
   input  logic                          rsp_stall,
   output logic                          rsp_valid,
   output logic signed [31:0]            rsp_mean_x,
   output logic signed [31:0]            rsp_mean_y,
   output logic [62:0]                   rsp_chi_square,
   output logic [62:0]                   rsp_max_dev_sq,
   output logic [6:0]                    rsp_dof_count,
   output logic [6:0]                    rsp_fit_total,
   output logic                          rsp_clip_found,
   output logic [5:0]                    rsp_clip_index,
   output logic                          rsp_set_overflow
);

   localparam int P  = POS_BITS;
   localparam int W  = WEIGHT_BITS;
   localparam int AW = $clog2(MAX_DETECTIONS);
   localparam int CW = $clog2(MAX_DETECTIONS + 1);
   localparam int MW = 2 * P + 4 * W + 1;
   localparam int PW = 64 + W;
   localparam int LW = P + W + 1;

   // Store and load counters.
   logic [MW-1:0] store_mem [MAX_DETECTIONS];
   logic [CW-1:0] load_cnt_ff;
   logic [CW-1:0] fit_cnt_ff;
   logic          ovf_ff;
   logic          full;
   logic          fit_in;

   // Load accumulation pipeline.
   logic                  l1_vld_ff, l2_vld_ff;
   logic signed [P-1:0]   l1_px_ff, l1_py_ff;
   logic [W-1:0]          l1_wx_ff, l1_wy_ff, l2_wx_ff, l2_wy_ff;
   logic signed [P+W:0]   l2_prx_ff, l2_pry_ff;
   logic signed [63:0]    sum_px_ff, sum_py_ff;
   logic [63:0]           sum_wx_ff, sum_wy_ff;

   // Divider.
   logic                  div_sel_ff;
   logic                  div_done;
   logic signed [31:0]    div_q;
   logic signed [31:0]    mean_x_ff, mean_y_ff;

   // Deviation pipeline.
   logic [AW-1:0]         rd_idx_ff;
   logic [MW-1:0]         rd_data_ff;
   logic                  p1_vld_ff, p2_vld_ff, p3_vld_ff, p4_vld_ff, p5_vld_ff;
   logic [AW-1:0]         p1_idx_ff, p2_idx_ff, p3_idx_ff, p4_idx_ff, p5_idx_ff;
   logic                  p2_fit_ff, p3_fit_ff, p4_fit_ff, p5_fit_ff;
   logic signed [P-1:0]   rd_x, rd_y;
   logic [W-1:0]          rd_wx, rd_wy, rd_cx, rd_cy;
   logic                  rd_fit;
   logic signed [32:0]    dx, dy;
   logic [31:0]           p2_mx_ff, p2_my_ff;
   logic [W-1:0]          p2_wx_ff, p2_wy_ff, p2_cx_ff, p2_cy_ff;
   logic [W-1:0]          p3_wx_ff, p3_wy_ff, p3_cx_ff, p3_cy_ff;
   logic [63:0]           p3_sqx_ff, p3_sqy_ff;
   logic [PW-1:0]         prod_fx, prod_fy, prod_cx, prod_cy;
   logic [62:0]           p4_fx_ff, p4_fy_ff, p4_cx_ff, p4_cy_ff;
   logic [63:0]           t_sum, d_sum;
   logic [62:0]           p5_t_ff, p5_d_ff;
   logic [63:0]           chi_sum;
   logic [62:0]           chi_ff, max_ff, worst_ff;
   logic                  found_ff;
   logic [AW-1:0]         widx_ff;

   logic [15:0]           fit16;
   logic [15:0]           widx16;

   assign full   = (load_cnt_ff == CW'(MAX_DETECTIONS));
   assign fit_in = !already_clipped && ((weight_x != '0) || (weight_y != '0));

   always_ff @(posedge clock) begin
      if (cmd.load_en && !full) begin
         store_mem[load_cnt_ff[AW-1:0]] <=
            {fit_in, clip_wy, clip_wx, weight_y, weight_x, pos_y, pos_x};
      end
      if (cmd.pass_issue) begin
         rd_data_ff <= store_mem[rd_idx_ff];
      end
   end

   // Counters, overflow and load sums.
   always_ff @(posedge clock) begin
      if (reset || cmd.finish) begin
         load_cnt_ff <= '0;
         fit_cnt_ff  <= '0;
         ovf_ff      <= 1'b0;
         l1_vld_ff   <= 1'b0;
         l2_vld_ff   <= 1'b0;
         sum_px_ff   <= '0;
         sum_py_ff   <= '0;
         sum_wx_ff   <= '0;
         sum_wy_ff   <= '0;
      end else begin
         l1_vld_ff <= cmd.load_en && !full && fit_in;
         l2_vld_ff <= l1_vld_ff;
         if (cmd.load_en) begin
            if (full) begin
               ovf_ff <= 1'b1;
            end else begin
               load_cnt_ff <= load_cnt_ff + CW'(1);
               if (fit_in) begin
                  fit_cnt_ff <= fit_cnt_ff + CW'(1);
               end
            end
         end
         if (l2_vld_ff) begin
            sum_px_ff <= sum_px_ff + 64'(l2_prx_ff);
            sum_py_ff <= sum_py_ff + 64'(l2_pry_ff);
            sum_wx_ff <= sum_wx_ff + 64'(l2_wx_ff);
            sum_wy_ff <= sum_wy_ff + 64'(l2_wy_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      l1_px_ff  <= pos_x;
      l1_py_ff  <= pos_y;
      l1_wx_ff  <= weight_x;
      l1_wy_ff  <= weight_y;
      l2_prx_ff <= LW'(l1_px_ff) * LW'($signed({1'b0, l1_wx_ff}));
      l2_pry_ff <= LW'(l1_py_ff) * LW'($signed({1'b0, l1_wy_ff}));
      l2_wx_ff  <= l1_wx_ff;
      l2_wy_ff  <= l1_wy_ff;
   end

   // Centroid divisions, x then y through one divider.
   wcsc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (cmd.div_sel ? sum_py_ff : sum_px_ff),
      .divisor  (cmd.div_sel ? sum_wy_ff : sum_wx_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         div_sel_ff <= cmd.div_sel;
      end
      if (div_done) begin
         if (div_sel_ff) begin
            mean_y_ff <= div_q;
         end else begin
            mean_x_ff <= div_q;
         end
      end
   end

   // Deviation pipeline over the stored entries.
   always_comb begin
      rd_x   = $signed(rd_data_ff[P-1:0]);
      rd_y   = $signed(rd_data_ff[2*P-1:P]);
      rd_wx  = rd_data_ff[2*P+W-1:2*P];
      rd_wy  = rd_data_ff[2*P+2*W-1:2*P+W];
      rd_cx  = rd_data_ff[2*P+3*W-1:2*P+2*W];
      rd_cy  = rd_data_ff[2*P+4*W-1:2*P+3*W];
      rd_fit = rd_data_ff[MW-1];
      dx     = 33'(rd_x) - 33'(mean_x_ff);
      dy     = 33'(rd_y) - 33'(mean_y_ff);
      prod_fx = PW'(p3_sqx_ff) * PW'(p3_wx_ff);
      prod_fy = PW'(p3_sqy_ff) * PW'(p3_wy_ff);
      prod_cx = PW'(p3_sqx_ff) * PW'(p3_cx_ff);
      prod_cy = PW'(p3_sqy_ff) * PW'(p3_cy_ff);
      t_sum   = 64'(p4_fx_ff) + 64'(p4_fy_ff);
      d_sum   = 64'(p4_cx_ff) + 64'(p4_cy_ff);
      chi_sum = 64'(chi_ff) + 64'(p5_t_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
         p2_vld_ff <= 1'b0;
         p3_vld_ff <= 1'b0;
         p4_vld_ff <= 1'b0;
         p5_vld_ff <= 1'b0;
         rd_idx_ff <= '0;
      end else begin
         p1_vld_ff <= cmd.pass_issue;
         p2_vld_ff <= p1_vld_ff;
         p3_vld_ff <= p2_vld_ff;
         p4_vld_ff <= p3_vld_ff;
         p5_vld_ff <= p4_vld_ff;
         if (cmd.pass_start) begin
            rd_idx_ff <= '0;
         end else if (cmd.pass_issue) begin
            rd_idx_ff <= rd_idx_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      p1_idx_ff <= rd_idx_ff;
      p2_idx_ff <= p1_idx_ff;
      p2_fit_ff <= rd_fit;
      p2_mx_ff  <= dx[32] ? 32'(-dx) : dx[31:0];
      p2_my_ff  <= dy[32] ? 32'(-dy) : dy[31:0];
      p2_wx_ff  <= rd_wx;
      p2_wy_ff  <= rd_wy;
      p2_cx_ff  <= rd_cx;
      p2_cy_ff  <= rd_cy;
      p3_idx_ff <= p2_idx_ff;
      p3_fit_ff <= p2_fit_ff;
      p3_sqx_ff <= 64'(p2_mx_ff) * 64'(p2_mx_ff);
      p3_sqy_ff <= 64'(p2_my_ff) * 64'(p2_my_ff);
      p3_wx_ff  <= p2_wx_ff;
      p3_wy_ff  <= p2_wy_ff;
      p3_cx_ff  <= p2_cx_ff;
      p3_cy_ff  <= p2_cy_ff;
      p4_idx_ff <= p3_idx_ff;
      p4_fit_ff <= p3_fit_ff;
      p4_fx_ff  <= (prod_fx[PW-1:63] != '0) ? wcsc_pkg::SAT63 : prod_fx[62:0];
      p4_fy_ff  <= (prod_fy[PW-1:63] != '0) ? wcsc_pkg::SAT63 : prod_fy[62:0];
      p4_cx_ff  <= (prod_cx[PW-1:63] != '0) ? wcsc_pkg::SAT63 : prod_cx[62:0];
      p4_cy_ff  <= (prod_cy[PW-1:63] != '0) ? wcsc_pkg::SAT63 : prod_cy[62:0];
      p5_idx_ff <= p4_idx_ff;
      p5_fit_ff <= p4_fit_ff;
      p5_t_ff   <= t_sum[63] ? wcsc_pkg::SAT63 : t_sum[62:0];
      p5_d_ff   <= d_sum[63] ? wcsc_pkg::SAT63 : d_sum[62:0];
   end

   // Chi-square, largest term and worst outlier; cleared when the result register is loaded.
   always_ff @(posedge clock) begin
      if (reset || cmd.finish) begin
         chi_ff   <= '0;
         max_ff   <= '0;
         worst_ff <= '0;
         found_ff <= 1'b0;
         widx_ff  <= '0;
      end else if (p5_vld_ff && p5_fit_ff) begin
         chi_ff <= chi_sum[63] ? wcsc_pkg::SAT63 : chi_sum[62:0];
         if (p5_t_ff > max_ff) begin
            max_ff <= p5_t_ff;
         end
         if ((p5_d_ff > clip_thr) && (p5_d_ff > worst_ff)) begin
            worst_ff <= p5_d_ff;
            widx_ff  <= p5_idx_ff;
            found_ff <= 1'b1;
         end
      end
   end

   // Result register.
   assign fit16  = 16'(fit_cnt_ff);
   assign widx16 = 16'(widx_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_mean_x       <= mean_x_ff;
         rsp_mean_y       <= mean_y_ff;
         rsp_chi_square   <= chi_ff;
         rsp_max_dev_sq   <= max_ff;
         rsp_dof_count    <= (fit16 > 16'd1) ? {fit16[5:0] - 6'd1, 1'b0} : 7'd0;
         rsp_fit_total    <= fit16[6:0];
         rsp_clip_found   <= found_ff;
         rsp_clip_index   <= found_ff ? widx16[5:0] : 6'd0;
         rsp_set_overflow <= ovf_ff;
      end
   end

   always_comb begin
      sts.load_busy  = l1_vld_ff || l2_vld_ff;
      sts.div_done   = div_done;
      sts.fit_gt1    = (fit_cnt_ff > CW'(1));
      sts.issue_last = (CW'(rd_idx_ff) == (load_cnt_ff - CW'(1)));
      sts.pipe_busy  = p1_vld_ff || p2_vld_ff || p3_vld_ff || p4_vld_ff || p5_vld_ff;
      sts.out_free   = !rsp_valid || !rsp_stall;
   end

endmodule

/* hw/rtl/wcsc_ctrl.sv */
// Controller state machine: loading, two centroid divisions, the store pass and hand-off.
// Depends on wcsc_pkg.
`timescale 1ns / 1ps

module wcsc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_last_item,
   output logic              req_stall,
   input  wcsc_pkg::sts_type sts,
   output wcsc_pkg::cmd_type cmd
);

   wcsc_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wcsc_pkg::ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         wcsc_pkg::ST_LOAD: begin
            req_stall   = 1'b0;
            cmd.load_en = req_valid;
            if (req_valid && req_last_item) begin
               state_in = wcsc_pkg::ST_LOAD_DRAIN;
            end
         end
         wcsc_pkg::ST_LOAD_DRAIN: begin
            if (!sts.load_busy) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = 1'b0;
               state_in      = wcsc_pkg::ST_DIV_X;
            end
         end
         wcsc_pkg::ST_DIV_X: begin
            if (sts.div_done) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = 1'b1;
               state_in      = wcsc_pkg::ST_DIV_Y;
            end
         end
         wcsc_pkg::ST_DIV_Y: begin
            if (sts.div_done) begin
               if (sts.fit_gt1) begin
                  cmd.pass_start = 1'b1;
                  state_in       = wcsc_pkg::ST_PASS;
               end else begin
                  state_in = wcsc_pkg::ST_FINISH;
               end
            end
         end
         wcsc_pkg::ST_PASS: begin
            cmd.pass_issue = 1'b1;
            if (sts.issue_last) begin
               state_in = wcsc_pkg::ST_PASS_DRAIN;
            end
         end
         wcsc_pkg::ST_PASS_DRAIN: begin
            if (!sts.pipe_busy) begin
               state_in = wcsc_pkg::ST_FINISH;
            end
         end
         wcsc_pkg::ST_FINISH: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = wcsc_pkg::ST_LOAD;
            end
         end
         default: begin
            state_in = wcsc_pkg::ST_LOAD;
         end
      endcase
   end

endmodule

/* hw/rtl/weighted_centroid_sigma_clip_top.sv */
// Weighted centroid with sigma clipping over one match set of detections. Detections
// arrive one word per cycle on the req_ channel while req_stall is low and are written
// to an on-chip store of MAX_DETECTIONS entries while the fit sums build up; the word
// with last_item closes the set. The block then runs two 64-step restoring divisions on
// one shared divider for the x and y centroids and, when more than one detection fits,
// a pipelined pass that reads one stored entry per cycle through the deviation pipeline.
// One result word then goes to the rsp_ register, where it waits for the consumer while
// the next set already loads. The store needs no clearing after reset. The squared
// threshold is written through the csr_ channel, which is always ready and must only be
// used between sets.
// Depends on wcsc_pkg, wcsc_ctrl, wcsc_datapath and wcsc_div.
`timescale 1ns / 1ps

module weighted_centroid_sigma_clip_top #(
   parameter int MAX_DETECTIONS = 64,
   parameter int POS_BITS       = 32,
   parameter int WEIGHT_BITS    = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   // Configuration write channel.
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [62:0]                 csr_clip_threshold_sq,
   // Detection input channel.
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [POS_BITS-1:0]  req_pos_x,
   input  logic signed [POS_BITS-1:0]  req_pos_y,
   input  logic [WEIGHT_BITS-1:0]      req_weight_x,
   input  logic [WEIGHT_BITS-1:0]      req_weight_y,
   input  logic [WEIGHT_BITS-1:0]      req_clip_wx,
   input  logic [WEIGHT_BITS-1:0]      req_clip_wy,
   input  logic                        req_already_clipped,
   input  logic                        req_last_item,
   // Result channel.
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [31:0]          rsp_mean_x,
   output logic signed [31:0]          rsp_mean_y,
   output logic [62:0]                 rsp_chi_square,
   output logic [62:0]                 rsp_max_dev_sq,
   output logic [6:0]                  rsp_dof_count,
   output logic [6:0]                  rsp_fit_total,
   output logic                        rsp_clip_found,
   output logic [5:0]                  rsp_clip_index,
   output logic                        rsp_set_overflow
);

   wcsc_pkg::cmd_type cmd;
   wcsc_pkg::sts_type sts;
   logic [62:0]       clip_thr_ff;

   // The threshold register keeps its value across sets; only reset clears it.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_thr_ff <= '0;
      end else if (csr_valid) begin
         clip_thr_ff <= csr_clip_threshold_sq;
      end
   end

   wcsc_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_last_item (req_last_item),
      .req_stall     (req_stall),
      .sts           (sts),
      .cmd           (cmd)
   );

   wcsc_datapath #(
      .MAX_DETECTIONS (MAX_DETECTIONS),
      .POS_BITS       (POS_BITS),
      .WEIGHT_BITS    (WEIGHT_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .pos_x            (req_pos_x),
      .pos_y            (req_pos_y),
      .weight_x         (req_weight_x),
      .weight_y         (req_weight_y),
      .clip_wx          (req_clip_wx),
      .clip_wy          (req_clip_wy),
      .already_clipped  (req_already_clipped),
      .clip_thr         (clip_thr_ff),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_mean_x       (rsp_mean_x),
      .rsp_mean_y       (rsp_mean_y),
      .rsp_chi_square   (rsp_chi_square),
      .rsp_max_dev_sq   (rsp_max_dev_sq),
      .rsp_dof_count    (rsp_dof_count),
      .rsp_fit_total    (rsp_fit_total),
      .rsp_clip_found   (rsp_clip_found),
      .rsp_clip_index   (rsp_clip_index),
      .rsp_set_overflow (rsp_set_overflow)
   );

endmodule

/* hw/rtl/wcsc_checker.sv */
// Port-level checks for the weighted centroid block, attached by a bind.
// Depends on weighted_centroid_sigma_clip_top.
`timescale 1ns / 1ps

module wcsc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [62:0] rsp_chi_square,
   input logic [62:0] rsp_max_dev_sq,
   input logic [6:0]  rsp_dof_count,
   input logic        rsp_clip_found,
   input logic [5:0]  rsp_clip_index
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_chi_square)
         && $stable(rsp_clip_index))
      else $error("result word changed while stalled");

   a_max_le_chi: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_max_dev_sq <= rsp_chi_square)
      else $error("largest deviation exceeds chi-square");

   a_no_clip_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_clip_found |-> rsp_clip_index == 6'd0)
      else $error("clip index set without an outlier");

   a_dof_even: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_dof_count[0])
      else $error("degrees of freedom are odd");

endmodule

bind weighted_centroid_sigma_clip_top wcsc_checker u_wcsc_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_chi_square (rsp_chi_square),
   .rsp_max_dev_sq (rsp_max_dev_sq),
   .rsp_dof_count  (rsp_dof_count),
   .rsp_clip_found (rsp_clip_found),
   .rsp_clip_index (rsp_clip_index)
);

/* bench/tb_top.sv */
// Self-checking bench for the weighted centroid and sigma clip block.
// Drives match sets of detections and compares each result word against a local predictor.
// Depends on weighted_centroid_sigma_clip_top.
`timescale 1ns / 1ps

// One expected or observed result word.
typedef struct {
   logic signed [31:0] mean_x;
   logic signed [31:0] mean_y;
   logic [62:0] chi;
   logic [62:0] maxd;
   logic [6:0] dof;
   logic [6:0] fit;
   logic found;
   logic [5:0] idx;
   logic ovf;
} centroid_result_type;

class centroid_scoreboard;
   localparam int DEPTH = 64;
   localparam logic [63:0] SAT = 64'h7FFF_FFFF_FFFF_FFFF;

   logic signed [31:0] xs[DEPTH];
   logic signed [31:0] ys[DEPTH];
   logic [15:0] fwx[DEPTH], fwy[DEPTH], cwx[DEPTH], cwy[DEPTH];
   bit fits[DEPTH];
   int unsigned n_loaded, n_fit;
   logic signed [63:0] sum_xw, sum_wx, sum_yw, sum_wy;
   bit ovf;
   logic [62:0] threshold;
   centroid_result_type pending_results[$];
   int errors;

   function new();
      threshold = 0;
      errors = 0;
      clear_set();
   endfunction

   function void clear_set();
      n_loaded = 0;
      n_fit = 0;
      sum_xw = 0;
      sum_wx = 0;
      sum_yw = 0;
      sum_wy = 0;
      ovf = 0;
   endfunction

   function logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
      logic [64:0] s;
      s = a + b;
      return (s > SAT) ? SAT : s[63:0];
   endfunction

   function logic [63:0] weighted_sq(logic signed [63:0] p, logic signed [63:0] m,
                                     logic [15:0] w);
      logic signed [63:0] d;
      logic [63:0] mag;
      logic [127:0] prod;
      d = p - m;
      mag = d < 0 ? -d : d;
      prod = mag * mag;
      prod = prod * w;
      return (prod > SAT) ? SAT : prod[63:0];
   endfunction

   function void note_detection(logic signed [31:0] px, logic signed [31:0] py,
                                logic [15:0] wx, logic [15:0] wy, logic [15:0] cx,
                                logic [15:0] cy, bit clipped, bit last);
      centroid_result_type r;
      logic signed [63:0] mx, my;
      logic [63:0] chi, maxd, worst, t, dv;
      bit f;
      int widx;
      if (n_loaded < DEPTH) begin
         f = !clipped && !(wx == 0 && wy == 0);
         xs[n_loaded] = px;
         ys[n_loaded] = py;
         fwx[n_loaded] = wx;
         fwy[n_loaded] = wy;
         cwx[n_loaded] = cx;
         cwy[n_loaded] = cy;
         fits[n_loaded] = f;
         if (f) begin
            n_fit++;
            sum_xw += 64'(px) * $signed({48'd0, wx});
            sum_wx += wx;
            sum_yw += 64'(py) * $signed({48'd0, wy});
            sum_wy += wy;
         end
         n_loaded++;
      end else begin
         ovf = 1;
      end
      if (!last) return;
      mx = sum_wx > 0 ? sum_xw / sum_wx : 0;
      my = sum_wy > 0 ? sum_yw / sum_wy : 0;
      chi = 0;
      maxd = 0;
      worst = 0;
      widx = 0;
      r.found = 0;
      if (n_fit > 1) begin
         for (int i = 0; i < n_loaded; i++) begin
            if (!fits[i]) continue;
            t = sat_sum(weighted_sq(xs[i], mx, fwx[i]), weighted_sq(ys[i], my, fwy[i]));
            if (t > maxd) maxd = t;
            chi = sat_sum(chi, t);
            dv = sat_sum(weighted_sq(xs[i], mx, cwx[i]), weighted_sq(ys[i], my, cwy[i]));
            // Strictly greater keeps the first entry on ties.
            if (dv > {1'b0, threshold} && dv > worst) begin
               worst = dv;
               widx = i;
               r.found = 1;
            end
         end
      end
      r.mean_x = mx[31:0];
      r.mean_y = my[31:0];
      r.chi = chi[62:0];
      r.maxd = maxd[62:0];
      r.dof = n_fit > 1 ? 7'(2 * (n_fit - 1)) : 7'd0;
      r.fit = 7'(n_fit);
      r.idx = r.found ? 6'(widx) : 6'd0;
      r.ovf = ovf;
      pending_results = {pending_results, r};
      clear_set();
   endfunction

   function void report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch on %s: got %h, expected %h", what, got, want);
      errors++;
   endfunction

   function void check_result(centroid_result_type got);
      centroid_result_type e;
      if (pending_results.size() == 0) begin
         report("result word with nothing expected", 64'd1, 64'd0);
         return;
      end
      e = pending_results.pop_front();
      if (got.mean_x !== e.mean_x) report("mean_x", got.mean_x, e.mean_x);
      if (got.mean_y !== e.mean_y) report("mean_y", got.mean_y, e.mean_y);
      if (got.chi !== e.chi) report("chi_square", got.chi, e.chi);
      if (got.maxd !== e.maxd) report("max_dev_sq", got.maxd, e.maxd);
      if (got.dof !== e.dof) report("dof_count", got.dof, e.dof);
      if (got.fit !== e.fit) report("fit_total", got.fit, e.fit);
      if (got.found !== e.found) report("clip_found", got.found, e.found);
      if (got.idx !== e.idx) report("clip_index", got.idx, e.idx);
      if (got.ovf !== e.ovf) report("set_overflow", got.ovf, e.ovf);
   endfunction
endclass

module tb_top;

   logic clock = 0;
   logic reset = 1;
   logic csr_valid = 0;
   logic csr_ready;
   logic [62:0] csr_clip_threshold_sq = 0;
   logic req_valid = 0;
   logic req_stall;
   logic signed [31:0] req_pos_x = 0, req_pos_y = 0;
   logic [15:0] req_weight_x = 0, req_weight_y = 0, req_clip_wx = 0, req_clip_wy = 0;
   logic req_already_clipped = 0, req_last_item = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [31:0] rsp_mean_x, rsp_mean_y;
   logic [62:0] rsp_chi_square, rsp_max_dev_sq;
   logic [6:0] rsp_dof_count, rsp_fit_total;
   logic rsp_clip_found;
   logic [5:0] rsp_clip_index;
   logic rsp_set_overflow;

   centroid_scoreboard sb = new();
   int rsp_mode = 0;
   int burst_left = 0;
   int sent_words = 0;

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   weighted_centroid_sigma_clip_top u_top (.*);

   // The receiver stalls on its own pattern: long open stretches, sparse and dense random
   // stalls, switched at random moments so stalls land on every phase.
   always @(negedge clock) begin
      int c;
      c = $urandom_range(0, 299);
      if (c == 0) rsp_mode <= $urandom_range(0, 2);
      case (rsp_mode)
         0: rsp_stall <= 0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         default: rsp_stall <= ($urandom_range(0, 1) == 0);
      endcase
   end

   // Every accepted result word goes straight to the scoreboard.
   always @(posedge clock) begin
      centroid_result_type r;
      if (!reset && rsp_valid && !rsp_stall) begin
         r.mean_x = rsp_mean_x;
         r.mean_y = rsp_mean_y;
         r.chi = rsp_chi_square;
         r.maxd = rsp_max_dev_sq;
         r.dof = rsp_dof_count;
         r.fit = rsp_fit_total;
         r.found = rsp_clip_found;
         r.idx = rsp_clip_index;
         r.ovf = rsp_set_overflow;
         sb.check_result(r);
      end
   end

   // Sends one detection word. Between bursts the sender may idle for a random gap;
   // valid is only lowered when a gap really follows.
   task automatic send_word(logic signed [31:0] px, logic signed [31:0] py,
                            logic [15:0] wx, logic [15:0] wy, logic [15:0] cx,
                            logic [15:0] cy, bit clipped, bit last);
      int gap;
      req_valid <= 1;
      req_pos_x <= px;
      req_pos_y <= py;
      req_weight_x <= wx;
      req_weight_y <= wy;
      req_clip_wx <= cx;
      req_clip_wy <= cy;
      req_already_clipped <= clipped;
      req_last_item <= last;
      do @(posedge clock); while (req_stall);
      sb.note_detection(px, py, wx, wy, cx, cy, clipped, last);
      sent_words++;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_valid <= 0;
            repeat (gap) @(negedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   // Writes the threshold once every expected word has come back and the block has
   // had time to finish its divisions and pass.
   task automatic write_threshold(logic [62:0] value);
      int guard;
      guard = 0;
      req_valid <= 0;
      while (sb.pending_results.size() != 0 && guard < 100000) begin
         @(negedge clock);
         guard++;
      end
      repeat (300) @(negedge clock);
      csr_valid <= 1;
      csr_clip_threshold_sq <= value;
      do @(posedge clock); while (!csr_ready);
      sb.threshold = value;
      @(negedge clock);
      csr_valid <= 0;
   endtask

   function automatic logic signed [31:0] rand_pos(int shape);
      case (shape)
         0: return $signed($urandom());
         1: return $signed($urandom_range(0, 2000)) - 1000;
         default: return 32'sd100000 + $signed($urandom_range(0, 64)) - 32;
      endcase
   endfunction

   function automatic logic [15:0] rand_weight();
      case ($urandom_range(0, 5))
         0: return 16'd0;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(0, 15));
         default: return 16'($urandom());
      endcase
   endfunction

   // One random match set of the given size; mostly well formed, with occasional
   // clipped or zero-weight entries and, rarely, sets that overrun the store.
   task automatic send_set(int count, int shape);
      for (int i = 0; i < count; i++)
         send_word(rand_pos(shape), rand_pos(shape), rand_weight(), rand_weight(),
                   rand_weight(), rand_weight(), $urandom_range(0, 7) == 0,
                   i == count - 1);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed: extremes of positions and weights, a clipped entry, zero weights.
      send_word(32'sh7FFF_FFFF, -32'sh8000_0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                0, 0);
      send_word(-32'sh8000_0000, 32'sh7FFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                0, 0);
      send_word(0, 0, 16'd5, 16'd0, 16'd1, 16'd1, 1, 0);
      send_word(5, 5, 16'd0, 16'd0, 16'd1, 16'd1, 0, 1);
      // Single fitting entry: no chi-square, no clip.
      send_word(123, -456, 16'd7, 16'd9, 16'd3, 16'd3, 0, 1);
      // Zero weight sum on the y axis gives a zero mean there.
      send_word(10, 999, 16'd1, 16'd0, 16'd1, 16'd1, 0, 0);
      send_word(20, -999, 16'd1, 16'd0, 16'd1, 16'd1, 0, 1);
      // Tie between two symmetric outliers: the first one wins.
      send_word(-10, 0, 16'd1, 16'd1, 16'd1, 16'd1, 0, 0);
      send_word(10, 0, 16'd1, 16'd1, 16'd1, 16'd1, 0, 1);
      // Nothing at all fits.
      send_word(1, 1, 16'd1, 16'd1, 16'd1, 16'd1, 1, 1);
      write_threshold({63{1'b1}});
      send_set(6, 1);
      write_threshold(63'd50);
      // Overrun of the store, closed by a dropped word.
      send_set(66, 1);
      write_threshold(63'd0);

      // Random sets, mostly small, with threshold changes between phases.
      while (sent_words < 1050) begin
         int sz;
         sz = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 12);
         send_set(sz, $urandom_range(0, 2));
         if ($urandom_range(0, 24) == 0) begin
            case ($urandom_range(0, 2))
               0: write_threshold({63{1'b1}});
               1: write_threshold(63'($urandom_range(0, 100000)));
               default: write_threshold(63'({$urandom(), $urandom()}));
            endcase
         end
      end
      req_valid <= 0;

      while (sb.pending_results.size() != 0) @(negedge clock);
      repeat (300) @(negedge clock);
      if (sb.errors == 0)
         $display("weighted_centroid_sigma_clip_top test passed");
      else
         $display("weighted_centroid_sigma_clip_top test failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("weighted_centroid_sigma_clip_top test failed");
      $finish;
   end
endmodule

/* weighted_centroid_sigma_clip_top.f */
hw/rtl/wcsc_pkg.sv
hw/rtl/wcsc_div.sv
hw/rtl/wcsc_datapath.sv
hw/rtl/wcsc_ctrl.sv
hw/rtl/weighted_centroid_sigma_clip_top.sv
hw/rtl/wcsc_checker.sv
bench/tb_top.sv
